// ===== src/hcs_pkg.sv =====
// Shared types, constants and helpers for the HLS color shade core.
// No dependencies.
`default_nettype none
package hcs_pkg;
   localparam int CHANNEL_BITS_DEF     = 8;
   localparam int FACTOR_FRAC_BITS_DEF = 8;
   localparam int FACTOR_W             = 16;
   localparam logic [FACTOR_W-1:0] SHADE_RESET = 16'd256;
   localparam int QUO_W                = 17;
   localparam int XW                   = 21;

   localparam logic signed [XW-1:0] UNIT_X = 21'sd65536;

   typedef enum logic [1:0] {
      SEC_RISE,
      SEC_HIGH,
      SEC_FALL,
      SEC_LOW
   } sector_type;

   typedef struct packed {
      sector_type        sector;
      logic [QUO_W-1:0]  frac;
   } sector_sel_type;

   // x is six times the hue, Q.16, offset by the channel's sector shift
   function automatic sector_sel_type sector_of(input logic signed [XW-1:0] x);
      logic signed [XW-1:0] xa;
      logic signed [XW-1:0] fall;
      sector_sel_type s;
      xa = x;
      if (xa < 0) begin
         xa = XW'(xa + 6 * UNIT_X);
      end
      if (xa > 6 * UNIT_X) begin
         xa = XW'(xa - 6 * UNIT_X);
      end
      fall = XW'(4 * UNIT_X - xa);
      s.frac = '0;
      if (xa < UNIT_X) begin
         s.sector = SEC_RISE;
         s.frac   = xa[QUO_W-1:0];
      end else if (xa < 3 * UNIT_X) begin
         s.sector = SEC_HIGH;
      end else if (xa < 4 * UNIT_X) begin
         s.sector = SEC_FALL;
         s.frac   = fall[QUO_W-1:0];
      end else begin
         s.sector = SEC_LOW;
      end
      return s;
   endfunction
endpackage
`default_nettype wire

// ===== src/hcs_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the quotient must fit in QW bits.
`default_nettype none
module hcs_div #(
   parameter int NW = 24,
   parameter int DW = 9,
   parameter int QW = 17
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               out_valid,
   output logic [QW-1:0]      quo
);
   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] vld_ff;

   genvar i;
   generate
      for (i = 0; i < QW; i++) begin : g_stage
         logic [DW-1:0] src_rem;
         logic [QW-1:0] src_low;
         logic [QW-1:0] src_quo;
         logic [DW-1:0] src_den;
         logic          src_vld;
         logic [DW:0]   trial;
         logic          ge;
         logic [DW:0]   diff;
         if (i == 0) begin : g_first
            assign src_rem = {{(DW-(NW-QW)){1'b0}}, num[NW-1:QW]};
            assign src_low = num[QW-1:0];
            assign src_quo = '0;
            assign src_den = den;
            assign src_vld = in_valid;
         end else begin : g_next
            assign src_rem = rem_ff[i-1];
            assign src_low = low_ff[i-1];
            assign src_quo = quo_ff[i-1];
            assign src_den = den_ff[i-1];
            assign src_vld = vld_ff[i-1];
         end
         assign trial = {src_rem, src_low[QW-1]};
         assign ge    = trial >= {1'b0, src_den};
         assign diff  = trial - {1'b0, src_den};
         always_ff @(posedge clock) begin
            rem_ff[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[i] <= {src_low[QW-2:0], 1'b0};
            quo_ff[i] <= {src_quo[QW-2:0], ge};
            den_ff[i] <= src_den;
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else begin
               vld_ff[i] <= src_vld;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[QW-1];
   assign quo       = quo_ff[QW-1];
endmodule
`default_nettype wire

// ===== src/hls_color_shade_core.sv =====
// Top level: RGB to HLS, lightness/saturation shading, HLS back to RGB.
// Depends on hcs_pkg and hcs_div.
//
//  channel  ports            transfer when
//  request  start, req_*     start && !busy
//  result   rsp_strobe,rsp_* rsp_strobe (one cycle, no hold-off)
//  csr      csr_valid/ready  csr_valid && csr_ready
//
// One pixel per clock. The pipeline is an input register, a setup
// register, 17 divider stages and seven shading stages. busy is always
// low; the pipeline never stalls. Synchronous reset clears valid bits
// and sets shade_factor to 1.0.
`default_nettype none
module hls_color_shade_core #(
   parameter int CHANNEL_BITS     = hcs_pkg::CHANNEL_BITS_DEF,
   parameter int FACTOR_FRAC_BITS = hcs_pkg::FACTOR_FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [CHANNEL_BITS-1:0]     req_red_in,
   input  wire logic [CHANNEL_BITS-1:0]     req_green_in,
   input  wire logic [CHANNEL_BITS-1:0]     req_blue_in,
   input  wire logic [CHANNEL_BITS-1:0]     req_alpha_in,
   output logic                             rsp_strobe,
   output logic [CHANNEL_BITS-1:0]          rsp_red_out,
   output logic [CHANNEL_BITS-1:0]          rsp_green_out,
   output logic [CHANNEL_BITS-1:0]          rsp_blue_out,
   output logic [CHANNEL_BITS-1:0]          rsp_alpha_out,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [hcs_pkg::FACTOR_W-1:0] csr_data
);
   import hcs_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam logic [CB-1:0] CMAX = '1;
   localparam int SAT_NW = CB + 16;
   localparam int SAT_DW = CB + 1;
   localparam int HUE_NW = CB + 19;
   localparam int HUE_DW = CB + 3;
   localparam int LUM_NW = CB + 17;
   localparam int LUM_K  = 2 * CB + 16;
   localparam int LUM_RW = CB + 17;
   localparam int LUM_PW = LUM_NW - 1 + LUM_RW;
   localparam logic [LUM_RW-1:0] LUM_RECIP =
      LUM_RW'(((64'd1 << LUM_K) + 64'(CMAX) - 64'd1) / 64'(CMAX));
   localparam int SPW = QUO_W + FACTOR_W;
   localparam int PW = 18;
   localparam logic [QUO_W-1:0] ONE_Q = 17'd65536;
   localparam logic [PW-1:0] HALF_P = 18'd32768;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   logic [FACTOR_W-1:0] factor_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= SHADE_RESET;
      end else if (csr_valid) begin
         factor_ff <= csr_data;
      end
   end

   // input register
   logic          v0_ff;
   logic [CB-1:0] r0_ff, g0_ff, b0_ff, a0_ff;
   always_ff @(posedge clock) begin
      v0_ff <= reset ? 1'b0 : start;
      r0_ff <= req_red_in;
      g0_ff <= req_green_in;
      b0_ff <= req_blue_in;
      a0_ff <= req_alpha_in;
   end

   // min/max, numerators and divisors
   logic [CB-1:0]            mx, mn, dlt;
   logic [CB:0]              sum, den;
   logic signed [CB+3:0]     t, d6s;
   logic                     gray;
   logic [SAT_NW-1:0]        sat_num_in;
   logic [SAT_DW-1:0]        sat_den_in;
   logic [HUE_NW-1:0]        hue_num_in;
   logic [HUE_DW-1:0]        hue_den_in;
   logic [LUM_NW-1:0]        lum_num_in;
   always_comb begin
      mx = (r0_ff > g0_ff) ? r0_ff : g0_ff;
      if (b0_ff > mx) mx = b0_ff;
      mn = (r0_ff < g0_ff) ? r0_ff : g0_ff;
      if (b0_ff < mn) mn = b0_ff;
      dlt  = mx - mn;
      sum  = {1'b0, mx} + {1'b0, mn};
      den  = (sum <= {1'b0, CMAX}) ? sum : ({CMAX, 1'b0} - sum);
      gray = (mx == mn);
      d6s  = (CB+4)'(6 * $signed({4'b0, dlt}));
      if (r0_ff == mx) begin
         t = $signed({4'b0, g0_ff}) - $signed({4'b0, b0_ff});
      end else if (g0_ff == mx) begin
         t = (CB+4)'(2 * $signed({4'b0, dlt}) + $signed({4'b0, b0_ff})
                     - $signed({4'b0, r0_ff}));
      end else begin
         t = (CB+4)'(4 * $signed({4'b0, dlt}) + $signed({4'b0, r0_ff})
                     - $signed({4'b0, g0_ff}));
      end
      if (t < 0) t = t + d6s;
      if (gray) begin
         sat_num_in = '0;
         sat_den_in = SAT_DW'(1);
         hue_num_in = '0;
         hue_den_in = HUE_DW'(1);
      end else begin
         sat_num_in = {dlt, 16'b0} + SAT_NW'(den >> 1);
         sat_den_in = den;
         hue_num_in = {t[CB+2:0], 16'b0} + HUE_NW'(3 * {3'b0, dlt});
         hue_den_in = d6s[CB+2:0];
      end
      lum_num_in = {sum, 16'b0} + LUM_NW'(CMAX);
   end

   logic              v1_ff;
   logic [SAT_NW-1:0] sat_num_ff;
   logic [SAT_DW-1:0] sat_den_ff;
   logic [HUE_NW-1:0] hue_num_ff;
   logic [HUE_DW-1:0] hue_den_ff;
   logic [LUM_NW-1:0] lum_num_ff;
   logic [CB-1:0]     a1_ff;
   always_ff @(posedge clock) begin
      v1_ff      <= reset ? 1'b0 : v0_ff;
      sat_num_ff <= sat_num_in;
      sat_den_ff <= sat_den_in;
      hue_num_ff <= hue_num_in;
      hue_den_ff <= hue_den_in;
      lum_num_ff <= lum_num_in;
      a1_ff      <= a0_ff;
   end

   logic             sat_vld, hue_vld;
   logic [QUO_W-1:0] sat_q, hue_q, lum_q;

   hcs_div #(.NW(SAT_NW), .DW(SAT_DW), .QW(QUO_W)) u_sat_div (
      .clock(clock), .reset(reset), .in_valid(v1_ff),
      .num(sat_num_ff), .den(sat_den_ff), .out_valid(sat_vld), .quo(sat_q));
   hcs_div #(.NW(HUE_NW), .DW(HUE_DW), .QW(QUO_W)) u_hue_div (
      .clock(clock), .reset(reset), .in_valid(v1_ff),
      .num(hue_num_ff), .den(hue_den_ff), .out_valid(hue_vld), .quo(hue_q));

   // lightness: halve, then divide by CMAX with a reciprocal multiply
   logic [LUM_PW-1:0] lum_prod;
   assign lum_prod = LUM_PW'(lum_num_ff[LUM_NW-1:1]) * LUM_PW'(LUM_RECIP);

   logic [QUO_W-1:0] lum_dly_ff [QUO_W];
   always_ff @(posedge clock) begin
      lum_dly_ff[0] <= lum_prod[LUM_K +: QUO_W];
      for (int k = 1; k < QUO_W; k++) begin
         lum_dly_ff[k] <= lum_dly_ff[k-1];
      end
   end
   assign lum_q = lum_dly_ff[QUO_W-1];

   logic [CB-1:0] alpha_dly_ff [QUO_W];
   always_ff @(posedge clock) begin
      alpha_dly_ff[0] <= a1_ff;
      for (int k = 1; k < QUO_W; k++) begin
         alpha_dly_ff[k] <= alpha_dly_ff[k-1];
      end
   end

   // stage A: factor products
   logic           va_ff;
   logic [SPW-1:0] lprod_ff, sprod_ff;
   logic [15:0]    hue_a_ff;
   logic [CB-1:0]  a_a_ff;
   always_ff @(posedge clock) begin
      va_ff    <= reset ? 1'b0 : (sat_vld & hue_vld);
      lprod_ff <= SPW'(lum_q) * SPW'(factor_ff);
      sprod_ff <= SPW'(sat_q) * SPW'(factor_ff);
      hue_a_ff <= hue_q[15:0];
      a_a_ff   <= alpha_dly_ff[QUO_W-1];
   end

   // stage B: round and clamp
   localparam logic [SPW:0] FHALF = (SPW+1)'(1) << (FACTOR_FRAC_BITS - 1);
   logic [SPW:0] lsh, ssh;
   assign lsh = ({1'b0, lprod_ff} + FHALF) >> FACTOR_FRAC_BITS;
   assign ssh = ({1'b0, sprod_ff} + FHALF) >> FACTOR_FRAC_BITS;

   logic             vb_ff;
   logic [QUO_W-1:0] lb_ff, sb_ff;
   logic [15:0]      hue_b_ff;
   logic [CB-1:0]    a_b_ff;
   always_ff @(posedge clock) begin
      vb_ff    <= reset ? 1'b0 : va_ff;
      lb_ff    <= (lsh > (SPW+1)'(ONE_Q)) ? ONE_Q : lsh[QUO_W-1:0];
      sb_ff    <= (ssh > (SPW+1)'(ONE_Q)) ? ONE_Q : ssh[QUO_W-1:0];
      hue_b_ff <= hue_a_ff;
      a_b_ff   <= a_a_ff;
   end

   // stage C: L * S
   logic             vc_ff;
   logic [33:0]      ls_prod_ff;
   logic [QUO_W-1:0] lc_ff, sc_ff;
   logic [15:0]      hue_c_ff;
   logic [CB-1:0]    a_c_ff;
   always_ff @(posedge clock) begin
      vc_ff      <= reset ? 1'b0 : vb_ff;
      ls_prod_ff <= 34'(lb_ff) * 34'(sb_ff);
      lc_ff      <= lb_ff;
      sc_ff      <= sb_ff;
      hue_c_ff   <= hue_b_ff;
      a_c_ff     <= a_b_ff;
   end

   // stage D: ramp ends and sector selection
   logic [33:0]          ls_r;
   logic [PW-1:0]        ls, pv, qv, two_l;
   logic [18:0]          x6;
   logic signed [XW-1:0] xs;
   sector_sel_type       sel_in [3];
   always_comb begin
      ls_r  = ls_prod_ff + 34'(HALF_P);
      ls    = ls_r[33:16];
      if (lc_ff <= ONE_Q >> 1) begin
         pv = PW'(lc_ff) + ls;
      end else begin
         pv = PW'(lc_ff) + PW'(sc_ff) - ls;
      end
      two_l = {lc_ff, 1'b0};
      qv    = (two_l >= pv) ? two_l - pv : '0;
      if (qv > pv) qv = pv;
      x6    = 19'(hue_c_ff) * 19'd6;
      xs    = $signed({2'b0, x6});
      sel_in[0] = sector_of(XW'(xs + 2 * UNIT_X));
      sel_in[1] = sector_of(xs);
      sel_in[2] = sector_of(XW'(xs - 2 * UNIT_X));
   end

   logic           vd_ff;
   logic [PW-1:0]  pd_ff, qd_ff;
   sector_sel_type sel_ff [3];
   logic [CB-1:0]  a_d_ff;
   always_ff @(posedge clock) begin
      vd_ff  <= reset ? 1'b0 : vc_ff;
      pd_ff  <= pv;
      qd_ff  <= qv;
      sel_ff <= sel_in;
      a_d_ff <= a_c_ff;
   end

   // stage E: ramp products
   logic           ve_ff;
   logic [PW-1:0]  pe_ff, qe_ff;
   logic [34:0]    ramp_ff [3];
   sector_type     sec_e_ff [3];
   logic [CB-1:0]  a_e_ff;
   always_ff @(posedge clock) begin
      ve_ff  <= reset ? 1'b0 : vd_ff;
      pe_ff  <= pd_ff;
      qe_ff  <= qd_ff;
      a_e_ff <= a_d_ff;
      for (int c = 0; c < 3; c++) begin
         ramp_ff[c]  <= 35'(pd_ff - qd_ff) * 35'(sel_ff[c].frac);
         sec_e_ff[c] <= sel_ff[c].sector;
      end
   end

   // stage F: channel value times channel max
   logic [34:0]   ramp_r [3];
   logic [PW-1:0] chv [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ramp_r[c] = ramp_ff[c] + 35'(HALF_P);
         unique case (sec_e_ff[c]) inside
            SEC_RISE, SEC_FALL: chv[c] = qe_ff + ramp_r[c][PW+15:16];
            SEC_HIGH:           chv[c] = pe_ff;
            default:            chv[c] = qe_ff;
         endcase
      end
   end

   logic             vf_ff;
   logic [PW+CB-1:0] vm_ff [3];
   logic [CB-1:0]    a_f_ff;
   always_ff @(posedge clock) begin
      vf_ff  <= reset ? 1'b0 : ve_ff;
      a_f_ff <= a_e_ff;
      for (int c = 0; c < 3; c++) begin
         vm_ff[c] <= (PW+CB)'(chv[c]) * (PW+CB)'(CMAX);
      end
   end

   // stage G: round, clamp, output register
   logic [PW+CB:0]  vm_r [3];
   logic [CB-1:0]   chan [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         vm_r[c] = ({1'b0, vm_ff[c]} + (PW+CB+1)'(HALF_P)) >> 16;
         chan[c] = (vm_r[c] > (PW+CB+1)'(CMAX)) ? CMAX : vm_r[c][CB-1:0];
      end
   end

   logic          vg_ff;
   logic [CB-1:0] ro_ff, go_ff, bo_ff, ao_ff;
   always_ff @(posedge clock) begin
      vg_ff <= reset ? 1'b0 : vf_ff;
      ro_ff <= chan[0];
      go_ff <= chan[1];
      bo_ff <= chan[2];
      ao_ff <= a_f_ff;
   end

   assign rsp_strobe    = vg_ff;
   assign rsp_red_out   = ro_ff;
   assign rsp_green_out = go_ff;
   assign rsp_blue_out  = bo_ff;
   assign rsp_alpha_out = ao_ff;
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for hls_color_shade_core: RGBA pixels through HLS shading.
// Depends on hcs_pkg and the core RTL; predicts each pixel in a scoreboard class.
`timescale 1ns / 100ps

class shade_scoreboard;
   typedef struct {
      logic [7:0] r, g, b, a;
   } pixel_type;

   pixel_type  pending[$];
   logic [15:0] factor;
   int         mismatches;
   int         checked;

   function new();
      factor     = hcs_pkg::SHADE_RESET;
      mismatches = 0;
      checked    = 0;
   endfunction

   function automatic longint scale_q16(longint v);
      longint r;
      r = (v * factor + 128) >> 8;
      return (r > 65536) ? 65536 : r;
   endfunction

   function automatic logic [7:0] to_chan(longint v);
      longint r;
      r = (v * 255 + 32768) >> 16;
      return (r > 255) ? 8'd255 : r[7:0];
   endfunction

   function automatic longint ramp(longint x, longint p, longint q);
      longint unit;
      unit = 65536;
      if (x < 0) x += 6 * unit;
      if (x > 6 * unit) x -= 6 * unit;
      if (x < unit) return q + (((p - q) * x + 32768) >> 16);
      if (x < 3 * unit) return p;
      if (x < 4 * unit) return q + (((p - q) * (4 * unit - x) + 32768) >> 16);
      return q;
   endfunction

   function automatic pixel_type shade(pixel_type px);
      longint r, g, b, mx, mn, lum, sat, hue, d, den, t, x, p, q;
      pixel_type o;
      r = px.r; g = px.g; b = px.b;
      mx = (r > g) ? r : g; if (b > mx) mx = b;
      mn = (r < g) ? r : g; if (b < mn) mn = b;
      sat = 0; hue = 0;
      lum = ((mx + mn) * 65536 + 255) / 510;
      if (mx != mn) begin
         d = mx - mn;
         den = (mx + mn <= 255) ? (mx + mn) : (510 - mx - mn);
         sat = (d * 65536 + den / 2) / den;
         if (r == mx) t = g - b;
         else if (g == mx) t = 2 * d + b - r;
         else t = 4 * d + r - g;
         if (t < 0) t += 6 * d;
         hue = ((t * 65536 + 3 * d) / (6 * d)) & 16'hFFFF;
      end
      lum = scale_q16(lum);
      sat = scale_q16(sat);
      o.a = px.a;
      if (sat == 0) begin
         o.r = to_chan(lum); o.g = o.r; o.b = o.r;
      end else begin
         x = hue * 6;
         if (lum <= 32768) p = (lum * (65536 + sat) + 32768) >> 16;
         else p = lum + sat - ((lum * sat + 32768) >> 16);
         q = (2 * lum >= p) ? 2 * lum - p : 0;
         if (q > p) q = p;
         o.r = to_chan(ramp(x + 131072, p, q));
         o.g = to_chan(ramp(x, p, q));
         o.b = to_chan(ramp(x - 131072, p, q));
      end
      return o;
   endfunction

   function void note_pixel(logic [7:0] r, g, b, a);
      pixel_type px;
      px.r = r; px.g = g; px.b = b; px.a = a;
      pending.push_back(shade(px));
   endfunction

   function void check_result(logic [7:0] r, g, b, a);
      pixel_type e;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h %h %h %h", r, g, b, a);
         return;
      end
      e = pending.pop_front();
      if (e.r !== r || e.g !== g || e.b !== b || e.a !== a) begin
         mismatches++;
         if (mismatches <= 10)
            $display("pixel %0d: expected %h %h %h %h, got %h %h %h %h",
                     checked, e.r, e.g, e.b, e.a, r, g, b, a);
      end
   endfunction
endclass

module tb_top;
   import hcs_pkg::*;

   localparam int LATENCY = QUO_W + 9;
   localparam longint CYCLE_LIMIT = 200000;

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic       busy;
   logic [7:0] req_red_in = 0, req_green_in = 0, req_blue_in = 0, req_alpha_in = 0;
   logic       rsp_strobe;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic [FACTOR_W-1:0] csr_data = 0;

   shade_scoreboard sb = new();
   longint cycles = 0;
   int     sender_idle = 0;
   int     pixels = 0;
   int     settings = 0;

   hls_color_shade_core dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("hls_color_shade_core: mismatch");
         $finish;
      end
      if (!reset && rsp_strobe)
         sb.check_result(rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out);
   end

   task automatic send_pixel(logic [7:0] r, g, b, a);
      while ($urandom_range(99) < sender_idle) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_red_in <= r; req_green_in <= g; req_blue_in <= b; req_alpha_in <= a;
      do @(posedge clock); while (busy);
      sb.note_pixel(r, g, b, a);
      pixels++;
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_factor(logic [15:0] f);
      csr_valid <= 1;
      csr_data  <= f;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.factor = f;
      settings++;
   endtask

   task automatic random_pixels(int n);
      logic [7:0] v;
      for (int i = 0; i < n; i++) begin
         v = 8'($urandom);
         case ($urandom_range(7))
            0: send_pixel(v, v, v, 8'($urandom));
            1: send_pixel(v, v, 8'($urandom), 8'($urandom));
            2: send_pixel(8'($urandom), v, v, 8'($urandom));
            default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         endcase
      end
   endtask

   initial begin
      logic [15:0] factors[6];
      factors = '{16'd256, 16'd0, 16'hFFFF, 16'd128, 16'd384, 16'd1};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, grays, each hue sector, max ties
      send_pixel(0, 0, 0, 0);
      send_pixel(255, 255, 255, 255);
      send_pixel(128, 128, 128, 8'hAA);
      send_pixel(255, 0, 0, 8'h55);
      send_pixel(0, 255, 0, 1);
      send_pixel(0, 0, 255, 254);
      send_pixel(255, 255, 0, 0);
      send_pixel(0, 255, 255, 0);
      send_pixel(255, 0, 255, 0);
      send_pixel(255, 0, 1, 0);
      send_pixel(255, 1, 0, 0);
      send_pixel(1, 0, 0, 0);
      send_pixel(254, 255, 255, 0);
      send_pixel(200, 100, 50, 77);
      send_pixel(50, 100, 200, 77);
      drain();
      for (int k = 0; k < 6; k++) begin
         sender_idle = (k < 2) ? 12 : (k < 4) ? 47 : 0;
         write_factor(factors[k]);
         random_pixels(120);
         drain();
      end
      $display("covered %0d pixels under %0d shade factors, checked %0d results",
               pixels, settings, sb.checked);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("hls_color_shade_core: match");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("hls_color_shade_core: mismatch");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
src/hcs_pkg.sv
src/hcs_div.sv
src/hls_color_shade_core.sv
bench/tb_top.sv
